@@ hw/rtl/cma_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_pkg
// Shared widths and the controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package cma_pkg;

  localparam int YEAR_W     = 14;
  localparam int MONTH_W    = 4;
  localparam int DATE_W     = YEAR_W + MONTH_W;
  localparam int MEAN_W     = 16;
  localparam int HALF_W     = 5;
  localparam int CNT_W      = 6;
  localparam int SEEN_W     = 7;
  localparam int DIV_BITS   = 4;
  localparam int OUT_DATA_W = 40;

  localparam logic [SEEN_W-1:0] SEEN_MAX = 7'd127;

  typedef struct packed {
    logic in_ready;
    logic accept;
    logic update;
    logic reg_start;
    logic fl_init;
    logic fl_read;
    logic fl_sub;
    logic fl_start;
    logic emit;
    logic fl_next;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic has_regular;
    logic end_seen;
    logic h_zero;
    logic flushing;
    logic fl_emit;
    logic k_zero;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

@@ hw/rtl/cma_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module cma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/cma_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_div
// Restoring divider of a window sum by a small count, DIV_BITS quotient
// bits per cycle. The remainder stays below the count (at most 62).
// ----------------------------------------------------------------------------
module cma_div #(
  parameter int VALUE_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [VALUE_BITS+cma_pkg::CNT_W-1:0]  dividend_i,
  input  logic [cma_pkg::CNT_W-1:0]             divisor_i,
  output logic                                  done_o,
  output logic [cma_pkg::MEAN_W-1:0]            quotient_o
);
  import cma_pkg::*;

  localparam int NSTEP  = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
  localparam int QW     = NSTEP * DIV_BITS;
  localparam int EXT_W  = QW + CNT_W;
  localparam int STEP_W = $clog2(NSTEP + 1);

  logic [EXT_W-1:0]     dividend_ext;
  logic [CNT_W-1:0]     rem_q, rem_d;
  logic [QW-1:0]        quo_q, quo_d;
  logic [CNT_W-1:0]     div_q;
  logic [CNT_W:0]       trial;
  logic [STEP_W-1:0]    step_q;
  logic                 busy_q;
  logic                 done_q;
  logic [QW+MEAN_W-1:0] quo_ext;

  assign dividend_ext = EXT_W'(dividend_i);

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    trial = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial = {rem_d, quo_d[QW-1]};
      quo_d = {quo_d[QW-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d    = CNT_W'(trial - {1'b0, div_q});
        quo_d[0] = 1'b1;
      end else begin
        rem_d = trial[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= STEP_W'(NSTEP);
    end else if (busy_q) begin
      step_q <= step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_ext[EXT_W-1 -: CNT_W];
      quo_q <= dividend_ext[QW-1:0];
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quo_ext    = {{MEAN_W{1'b0}}, quo_q};
  assign quotient_o = quo_ext[MEAN_W-1:0];
  assign done_o     = done_q;

endmodule

@@ hw/rtl/cma_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_datapath
// Sample and date rings, running window sum, flush walk, divider and
// output register.
// ----------------------------------------------------------------------------
module cma_datapath #(
  parameter int RING_DEPTH = 64,
  parameter int VALUE_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cma_pkg::cmd_t                  cmd_i,
  output cma_pkg::status_t               sts_o,
  input  logic                           cfg_wr_en_i,
  input  logic [cma_pkg::HALF_W-1:0]     cfg_wr_data_i,
  input  logic [cma_pkg::YEAR_W-1:0]     sample_year_i,
  input  logic [cma_pkg::MONTH_W-1:0]    sample_month_i,
  input  logic [VALUE_BITS-1:0]          sample_value_i,
  input  logic                           series_end_i,
  input  logic                           m_ready_i,
  output logic                           m_valid_o,
  output logic [cma_pkg::YEAR_W-1:0]     mean_year_o,
  output logic [cma_pkg::MONTH_W-1:0]    mean_month_o,
  output logic [cma_pkg::MEAN_W-1:0]     mean_value_o,
  output logic                           mean_last_o,
  output logic                           short_series_o
);
  import cma_pkg::*;

  localparam int AW     = $clog2(RING_DEPTH);
  localparam int SUM_W  = VALUE_BITS + CNT_W;
  localparam int HMAX   = (RING_DEPTH - 1) / 2;
  localparam int HCLAMP = (HMAX < 31) ? HMAX : 31;
  localparam int PW     = (AW > CNT_W) ? AW : CNT_W;
  localparam int XW     = PW + 1;

  function automatic logic [AW-1:0] slot_back(input logic [AW-1:0]    base,
                                               input logic [CNT_W-1:0] off);
    logic [XW-1:0] diff;
    diff = XW'(base) - XW'(off);
    if (diff[XW-1]) begin
      diff = diff + XW'(RING_DEPTH);
    end
    return diff[AW-1:0];
  endfunction

  logic [HALF_W-1:0]     half_window_q;
  logic [HALF_W-1:0]     h_q, h_eff, h_cfg;
  logic [CNT_W-1:0]      wlen_eff, wlen_q, fl_off;
  logic [VALUE_BITS-1:0] value_q;
  logic [DATE_W-1:0]     date_q;
  logic                  end_q;
  logic                  rm_q;
  logic [SEEN_W-1:0]     seen_q;
  logic [SUM_W-1:0]      sum_q;
  logic [AW-1:0]         wr_q, wr_next;
  logic [HALF_W-1:0]     k_q;
  logic                  flushing_q;
  logic                  last_q;
  logic                  short_q;

  logic                  val_re, date_re;
  logic [AW-1:0]         val_raddr, date_raddr;
  logic [VALUE_BITS-1:0] val_rdata;
  logic [DATE_W-1:0]     date_rdata;

  logic                  div_start, div_done;
  logic [CNT_W-1:0]      div_count;
  logic [MEAN_W-1:0]     quotient;

  logic                  m_valid_q;
  logic [DATE_W-1:0]     out_date_q;
  logic [MEAN_W-1:0]     out_mean_q;
  logic                  out_last_q;
  logic                  out_short_q;

  assign h_cfg    = (int'(half_window_q) > HCLAMP) ? HALF_W'(HCLAMP) : half_window_q;
  assign h_eff    = (seen_q == '0) ? h_cfg : h_q;
  assign wlen_eff = {h_eff, 1'b1};
  assign wlen_q   = {h_q, 1'b1};
  assign fl_off   = CNT_W'(k_q) + CNT_W'(h_q) + CNT_W'(1);
  assign wr_next  = (wr_q == AW'(RING_DEPTH - 1)) ? '0 : wr_q + AW'(1);

  // ring reads
  assign val_re     = cmd_i.accept | cmd_i.fl_read;
  assign val_raddr  = cmd_i.accept ? slot_back(wr_q, {h_eff, 1'b0}) : slot_back(wr_q, fl_off);
  assign date_re    = cmd_i.reg_start | cmd_i.fl_read;
  assign date_raddr = cmd_i.reg_start ? slot_back(wr_q, CNT_W'(h_q))
                                      : slot_back(wr_q, CNT_W'(k_q));

  cma_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (RING_DEPTH)
  ) u_value_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update),
    .waddr_i (wr_next),
    .wdata_i (value_q),
    .re_i    (val_re),
    .raddr_i (val_raddr),
    .rdata_o (val_rdata)
  );

  cma_ram #(
    .WIDTH (DATE_W),
    .DEPTH (RING_DEPTH)
  ) u_date_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update),
    .waddr_i (wr_next),
    .wdata_i (date_q),
    .re_i    (date_re),
    .raddr_i (date_raddr),
    .rdata_o (date_rdata)
  );

  // divider
  assign div_start = cmd_i.reg_start | cmd_i.fl_start;
  always_comb begin
    if (cmd_i.reg_start) begin
      div_count = (seen_q < SEEN_W'(wlen_q)) ? seen_q[CNT_W-1:0] : wlen_q;
    end else begin
      div_count = (SEEN_W'(fl_off) < seen_q) ? fl_off : seen_q[CNT_W-1:0];
    end
  end

  cma_div #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (div_count),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_window_q <= '0;
      h_q           <= '0;
      seen_q        <= '0;
      sum_q         <= '0;
      wr_q          <= AW'(RING_DEPTH - 1);
      k_q           <= '0;
      flushing_q    <= 1'b0;
      end_q         <= 1'b0;
      rm_q          <= 1'b0;
      m_valid_q     <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        half_window_q <= cfg_wr_data_i;
      end
      if (cmd_i.accept) begin
        h_q   <= h_eff;
        end_q <= series_end_i;
        rm_q  <= (seen_q >= SEEN_W'(wlen_eff));
      end
      if (cmd_i.update) begin
        sum_q <= sum_q - (rm_q ? SUM_W'(val_rdata) : '0) + SUM_W'(value_q);
        wr_q  <= wr_next;
        if (seen_q < SEEN_MAX) begin
          seen_q <= seen_q + SEEN_W'(1);
        end
      end
      if (cmd_i.fl_init) begin
        k_q        <= h_q - HALF_W'(1);
        flushing_q <= 1'b1;
      end
      if (cmd_i.fl_sub && (SEEN_W'(fl_off) < seen_q)) begin
        sum_q <= sum_q - SUM_W'(val_rdata);
      end
      if (cmd_i.fl_next) begin
        k_q <= k_q - HALF_W'(1);
      end
      if (cmd_i.clear) begin
        seen_q     <= '0;
        sum_q      <= '0;
        flushing_q <= 1'b0;
      end
      if (cmd_i.emit) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      value_q <= sample_value_i;
      date_q  <= {sample_year_i, sample_month_i};
    end
    if (cmd_i.reg_start) begin
      last_q  <= end_q & (h_q == '0);
      short_q <= seen_q < SEEN_W'(wlen_q);
    end
    if (cmd_i.fl_start) begin
      last_q  <= (k_q == '0);
      short_q <= seen_q < SEEN_W'(wlen_q);
    end
    if (cmd_i.emit) begin
      out_date_q  <= date_rdata;
      out_mean_q  <= quotient;
      out_last_q  <= last_q;
      out_short_q <= last_q & short_q;
    end
  end

  assign sts_o.has_regular = seen_q > SEEN_W'(h_q);
  assign sts_o.end_seen    = end_q;
  assign sts_o.h_zero      = (h_q == '0);
  assign sts_o.flushing    = flushing_q;
  assign sts_o.fl_emit     = SEEN_W'(k_q) < seen_q;
  assign sts_o.k_zero      = (k_q == '0);
  assign sts_o.div_done    = div_done;
  assign sts_o.out_free    = !m_valid_q || m_ready_i;

  assign m_valid_o      = m_valid_q;
  assign mean_year_o    = out_date_q[DATE_W-1:MONTH_W];
  assign mean_month_o   = out_date_q[MONTH_W-1:0];
  assign mean_value_o   = out_mean_q;
  assign mean_last_o    = out_last_q;
  assign short_series_o = out_short_q;

`ifndef SYNTH
  a_emit_needs_quotient: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> div_done)
    else $error("result loaded before divider finished");

  a_emit_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!m_valid_q || m_ready_i))
    else $error("output register overwritten");

  a_no_accept_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept |-> !flushing_q)
    else $error("beat accepted during flush");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (div_count != '0))
    else $error("divide by zero count");
`endif

endmodule

@@ hw/rtl/cma_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_ctrl
// Sequencer: sample update, centered result, end-of-series flush walk.
// ----------------------------------------------------------------------------
module cma_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  cma_pkg::status_t sts_i,
  output cma_pkg::cmd_t    cmd_o
);
  import cma_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_UPDATE   = 8'b0000_0010,
    S_REG      = 8'b0000_0100,
    S_DIV      = 8'b0000_1000,
    S_FL_RD    = 8'b0001_0000,
    S_FL_SUB   = 8'b0010_0000,
    S_FL_START = 8'b0100_0000,
    S_SPARE    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o          = '0;
    state_d        = state_q;
    cmd_o.in_ready = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = S_REG;
      end
      S_REG: begin
        if (sts_i.has_regular) begin
          cmd_o.reg_start = 1'b1;
          state_d         = S_DIV;
        end else if (sts_i.end_seen) begin
          cmd_o.fl_init = 1'b1;
          state_d       = S_FL_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        if (sts_i.div_done && sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.flushing) begin
            if (sts_i.k_zero) begin
              cmd_o.clear = 1'b1;
              state_d     = S_IDLE;
            end else begin
              cmd_o.fl_next = 1'b1;
              state_d       = S_FL_RD;
            end
          end else if (sts_i.end_seen) begin
            if (sts_i.h_zero) begin
              cmd_o.clear = 1'b1;
              state_d     = S_IDLE;
            end else begin
              cmd_o.fl_init = 1'b1;
              state_d       = S_FL_RD;
            end
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_FL_RD: begin
        cmd_o.fl_read = 1'b1;
        state_d       = S_FL_SUB;
      end
      S_FL_SUB: begin
        cmd_o.fl_sub = 1'b1;
        state_d      = S_FL_START;
      end
      S_FL_START: begin
        if (sts_i.fl_emit) begin
          cmd_o.fl_start = 1'b1;
          state_d        = S_DIV;
        end else if (sts_i.k_zero) begin
          cmd_o.clear = 1'b1;
          state_d     = S_IDLE;
        end else begin
          cmd_o.fl_next = 1'b1;
          state_d       = S_FL_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hw/rtl/centered_moving_average.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// centered_moving_average
// Centered moving average over a stream of dated samples.
// ----------------------------------------------------------------------------
// Each input beat carries one sample; the result for sample j is the
// truncated mean of samples j-h..j+h of its series (cut at both ends) and
// carries the date of sample j. h is half_window, clamped to
// (RING_DEPTH-1)/2 and taken at the first sample of a series. A result
// leaves as soon as sample j+h is in; the last beat of a series (tlast)
// flushes the last results (at most h), the final one marked by tlast and, if
// the series was shorter than 2h+1, by tuser. One sample is handled at a
// time: the next beat is taken only once the current one, its result and
// any flushed results are through the 4-bit-per-cycle divider and in the
// output register, so output stalls also hold the input. The rings need
// no clearing after reset.
module centered_moving_average #(
  parameter int RING_DEPTH = 64,
  parameter int VALUE_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_wr_en_i,
  input  logic [cma_pkg::HALF_W-1:0]        cfg_wr_data_i,   // half_window
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // sample_year[13:0], sample_month[17:14], sample_value[17+VALUE_BITS:18], zero pad
  input  logic [((18+VALUE_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic                              s_axis_tlast,    // series_end
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // mean_year[13:0], mean_month[17:14], mean_value[33:18], zero pad
  output logic [cma_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                              m_axis_tlast,    // mean_last
  output logic                              m_axis_tuser     // short_series
);
  import cma_pkg::*;

  localparam int VAL_LO = YEAR_W + MONTH_W;

  cmd_t                  cmd;
  status_t               sts;
  logic [YEAR_W-1:0]     mean_year;
  logic [MONTH_W-1:0]    mean_month;
  logic [MEAN_W-1:0]     mean_value;

  cma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cma_datapath #(
    .RING_DEPTH (RING_DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_wr_en_i    (cfg_wr_en_i),
    .cfg_wr_data_i  (cfg_wr_data_i),
    .sample_year_i  (s_axis_tdata[YEAR_W-1:0]),
    .sample_month_i (s_axis_tdata[VAL_LO-1:YEAR_W]),
    .sample_value_i (s_axis_tdata[VAL_LO+VALUE_BITS-1:VAL_LO]),
    .series_end_i   (s_axis_tlast),
    .m_ready_i      (m_axis_tready),
    .m_valid_o      (m_axis_tvalid),
    .mean_year_o    (mean_year),
    .mean_month_o   (mean_month),
    .mean_value_o   (mean_value),
    .mean_last_o    (m_axis_tlast),
    .short_series_o (m_axis_tuser)
  );

  assign s_axis_tready = cmd.in_ready;
  assign m_axis_tdata  = OUT_DATA_W'({mean_value, mean_month, mean_year});

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the centered moving average block.
// ----------------------------------------------------------------------------
// A directed set of short series covers the date and value extremes, the zero
// and the widest window, series shorter than the window and a window change
// while a series is still open. Random series with random windows follow.
// Every sample beat is run through an in-bench averaging model, and each
// result beat is compared field by field against the oldest expected mean.
// The sender and the receiver both stall at random. Once, the receiver holds
// off long enough for the block to back up its input.
// ----------------------------------------------------------------------------
module testbench;
  import cma_pkg::*;

  localparam int HIST_DEPTH  = 64;
  localparam int VAL_W       = 16;
  localparam int H_LIMIT     = (HIST_DEPTH - 1) / 2;
  localparam int DRAIN_WAIT  = 40;
  localparam int LONG_HOLD   = 400;
  localparam int STALL_LIMIT = 4000;
  localparam int RAND_ITEMS  = 160;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [VAL_W-1:0]   value;
    logic               series_end;
  } sample_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [MEAN_W-1:0]  value;
    logic               last;
    logic               is_short;
  } mean_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_wr_en_i = 1'b0;
  logic [HALF_W-1:0]  cfg_wr_data_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [39:0]        s_axis_tdata = '0;
  logic               s_axis_tlast = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic               m_axis_tlast;
  logic               m_axis_tuser;

  centered_moving_average dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  sample_t pending_samples[$];
  mean_t   expected_means[$];
  int      mismatch_cnt = 0;
  logic    src_steady = 1'b0;
  logic    sink_steady = 1'b0;

  // averaging model state
  logic [VAL_W-1:0]  val_hist [HIST_DEPTH];
  logic [DATE_W-1:0] date_hist [HIST_DEPTH];
  logic [SEEN_W-1:0] seen_cnt = '0;
  logic [31:0]       run_sum = '0;
  int unsigned       head = HIST_DEPTH - 1;
  int unsigned       h_cur = 0;
  logic [HALF_W-1:0] half_cfg = '0;

  function automatic int unsigned slot_ago(int unsigned k);
    return (head + HIST_DEPTH - (k % HIST_DEPTH)) % HIST_DEPTH;
  endfunction

  function automatic void push_mean(int unsigned k, logic [31:0] sum, int unsigned cnt,
                                    logic last, logic is_short);
    mean_t m;
    logic [DATE_W-1:0] d;
    logic [31:0] q;
    d = date_hist[slot_ago(k)];
    q = sum / cnt;
    m.year     = d[DATE_W-1:MONTH_W];
    m.month    = d[MONTH_W-1:0];
    m.value    = q[MEAN_W-1:0];
    m.last     = last;
    m.is_short = last & is_short;
    expected_means.push_back(m);
  endfunction

  task automatic average_sample(input sample_t s);
    int unsigned h, wlen, n, k, far_k, t;
    logic [31:0] part;
    if (seen_cnt == 0)
      h_cur = (half_cfg > H_LIMIT) ? H_LIMIT : half_cfg;
    h = h_cur;
    wlen = 2 * h + 1;
    if (seen_cnt >= wlen)
      run_sum = run_sum - val_hist[slot_ago(2 * h)];
    head = (head + 1) % HIST_DEPTH;
    val_hist[head] = s.value;
    date_hist[head] = {s.year, s.month};
    run_sum = run_sum + s.value;
    if (seen_cnt != SEEN_MAX)
      seen_cnt = seen_cnt + 1'b1;
    n = seen_cnt;
    if (n >= h + 1)
      push_mean(h, run_sum, (n < wlen) ? n : wlen, s.series_end && h == 0, n < wlen);
    if (s.series_end) begin
      k = h;
      while (k > 0) begin
        k--;
        if (k < n) begin
          far_k = k + h;
          if (far_k > n - 1)
            far_k = n - 1;
          part = '0;
          for (t = 0; t <= far_k; t++)
            part = part + val_hist[slot_ago(t)];
          push_mean(k, part, far_k + 1, k == 0, n < wlen);
        end
      end
      seen_cnt = '0;
      run_sum = '0;
    end
  endtask

  // sender: bursts of random length, random gaps
  int      burst_left = 0;
  int      gap_left = 0;
  sample_t sent_sample;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        average_sample(sent_sample);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0 && !src_steady) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          sent_sample = pending_samples.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {6'b0, sent_sample.value, sent_sample.month, sent_sample.year};
          s_axis_tlast  <= sent_sample.series_end;
          gap_left = 0;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off
  int   stall_left = 0;
  int   hold_left = 0;
  int   means_taken = 0;
  logic hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        means_taken++;
        if (!hold_done && means_taken >= 30 && pending_samples.size() > 8) begin
          hold_left = LONG_HOLD;
          hold_done = 1'b1;
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_steady) begin
        m_axis_tready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 7);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // result checker
  mean_t got_mean, want_mean;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_mean.year     = m_axis_tdata[13:0];
      got_mean.month    = m_axis_tdata[17:14];
      got_mean.value    = m_axis_tdata[33:18];
      got_mean.last     = m_axis_tlast;
      got_mean.is_short = m_axis_tuser;
      if (expected_means.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("ERROR: unexpected mean beat y=%0d m=%0d v=%0d l=%0b s=%0b",
                   got_mean.year, got_mean.month, got_mean.value, got_mean.last,
                   got_mean.is_short);
      end else begin
        want_mean = expected_means.pop_front();
        if (got_mean !== want_mean) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("ERROR: exp y=%0d m=%0d v=%0d l=%0b s=%0b got y=%0d m=%0d v=%0d l=%0b s=%0b",
                     want_mean.year, want_mean.month, want_mean.value, want_mean.last,
                     want_mean.is_short, got_mean.year, got_mean.month, got_mean.value,
                     got_mean.last, got_mean.is_short);
        end
      end
    end
  end

  // watchdog: cycles with work outstanding and no beat on either side
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (pending_samples.size() == 0 && !s_axis_tvalid && expected_means.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_half(input logic [HALF_W-1:0] h);
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= h;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    half_cfg = h;
  endtask

  task automatic add_sample(input int unsigned yr, input int unsigned mon,
                            input int unsigned val, input logic last);
    sample_t s;
    s.year       = yr[YEAR_W-1:0];
    s.month      = mon[MONTH_W-1:0];
    s.value      = val[VAL_W-1:0];
    s.series_end = last;
    pending_samples.push_back(s);
  endtask

  task automatic add_random_sample(input logic last);
    int unsigned yr, val;
    case ($urandom_range(0, 3))
      0:       yr = 0;
      1:       yr = (1 << YEAR_W) - 1;
      default: yr = $urandom_range(0, (1 << YEAR_W) - 1);
    endcase
    case ($urandom_range(0, 5))
      0:       val = 0;
      1:       val = (1 << VAL_W) - 1;
      2:       val = $urandom_range(0, 255);
      default: val = $urandom_range(0, (1 << VAL_W) - 1);
    endcase
    add_sample(yr, $urandom_range(0, (1 << MONTH_W) - 1), val, last);
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || s_axis_tvalid || expected_means.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  int unsigned rand_items;
  int unsigned h_pick, n_series, series_len, i, j;
  logic        series_open;
  logic        long_done;

  initial begin
    rand_items = 0;
    series_open = 1'b0;
    long_done = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero window: samples come back unchanged; date extremes and bad dates
    write_half(0);
    add_sample(0, 1, 0, 1'b0);
    add_sample(9999, 12, 16'hFFFF, 1'b0);
    add_sample(16383, 15, 16'h8000, 1'b0);
    add_sample(1, 0, 16'h7FFF, 1'b1);
    add_sample(5000, 6, 16'h1234, 1'b1);
    wait_drained();

    // series shorter than the window, then a single-sample series
    write_half(2);
    add_sample(2000, 3, 16'hFFFF, 1'b0);
    add_sample(2000, 4, 16'hFFFF, 1'b0);
    add_sample(2000, 5, 16'h0001, 1'b1);
    add_sample(2001, 1, 16'h00FF, 1'b1);
    wait_drained();

    // window change while a series is open applies to the next series only
    write_half(1);
    add_sample(1990, 1, 100, 1'b0);
    add_sample(1990, 2, 200, 1'b0);
    add_sample(1990, 3, 300, 1'b0);
    add_sample(1990, 4, 400, 1'b0);
    wait_drained();
    write_half(3);
    add_sample(1990, 5, 500, 1'b0);
    add_sample(1990, 6, 600, 1'b0);
    add_sample(1990, 7, 700, 1'b1);
    wait_drained();

    // widest window, all values at full scale
    write_half(31);
    for (i = 0; i < 5; i++)
      add_sample(3000 + i, 8, 16'hFFFF, i == 4);
    wait_drained();

    while (rand_items < RAND_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       h_pick = 0;
        1:       h_pick = 31;
        2, 3:    h_pick = $urandom_range(1, 4);
        default: h_pick = $urandom_range(0, 31);
      endcase
      src_steady  = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      write_half(h_pick[HALF_W-1:0]);
      n_series = (h_pick >= 16) ? 1 : $urandom_range(1, 3);
      for (j = 0; j < n_series; j++) begin
        if (!long_done && rand_items > 40) begin
          series_len = 130;
          long_done = 1'b1;
        end else if ($urandom_range(0, 2) == 0) begin
          series_len = $urandom_range(1, 2 * h_pick + 1);
        end else begin
          series_len = $urandom_range(2 * h_pick + 1, 2 * h_pick + 12);
        end
        series_open = (j == n_series - 1) && ($urandom_range(0, 4) == 0);
        for (i = 0; i < series_len; i++)
          add_random_sample((i == series_len - 1) && !series_open);
        rand_items += series_len;
      end
      wait_drained();
    end
    if (series_open) begin
      add_random_sample(1'b1);
      wait_drained();
    end

    if (mismatch_cnt == 0 && expected_means.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/cma_pkg.sv
hw/rtl/cma_ram.sv
hw/rtl/cma_div.sv
hw/rtl/cma_datapath.sv
hw/rtl/cma_ctrl.sv
hw/rtl/centered_moving_average.sv
tb/sv/testbench.sv
